>>> rtl/rds_pkg.sv
// ----------------------------------------------------------------------------
// rds_pkg
// Shared widths and elaboration-time helpers for the range digit sum block.
// ----------------------------------------------------------------------------
package rds_pkg;

	localparam int BOUND_W = 54;
	localparam int TOTAL_W = 60;

	// 10^n - 1 as a 64-bit constant, for elaboration only
	function automatic logic [63:0] pow10_m1(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < n; k++) begin
			p = p * 64'd10;
		end
		return p - 64'd1;
	endfunction

endpackage

>>> rtl/rds_table.sv
// ----------------------------------------------------------------------------
// rds_table
// Loose suffix table memory. Built after reset by a sequencer, then read by
// the walk through a registered synchronous read port.
// ----------------------------------------------------------------------------
module rds_table #(
	parameter int MAX_DIGITS = 16,
	parameter int SPAN       = 9 * MAX_DIGITS + 1,
	parameter int DEPTH      = MAX_DIGITS * SPAN,
	parameter int ADDR_W     = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [ADDR_W-1:0]          rd_addr,
	output logic [rds_pkg::TOTAL_W-1:0] rd_data,
	output logic                       built
);
	import rds_pkg::*;

	typedef enum logic [1:0] {ROW0, ROWN, DONE} bstate_t;

	bstate_t              state_q;
	logic [ADDR_W-1:0]    wr_addr_q;
	logic [7:0]           s_q;
	logic [3:0]           i_q;
	logic [TOTAL_W-1:0]   acc_q;

	logic [TOTAL_W-1:0]   mem [DEPTH];
	logic [TOTAL_W-1:0]   rdata_q;

	logic                 we;
	logic [TOTAL_W-1:0]   wdata;
	logic                 b_rd;
	logic [ADDR_W-1:0]    b_addr;
	logic                 short;
	logic                 last;

	assign short = ({1'b0, s_q} + 9'd9) >= 9'(SPAN);
	assign last  = wr_addr_q == ADDR_W'(DEPTH - 1);
	assign b_addr = wr_addr_q - ADDR_W'(SPAN) + ADDR_W'(i_q);

	always_comb begin
		we    = 1'b0;
		wdata = acc_q + rdata_q;
		b_rd  = 1'b0;
		case (state_q)
			ROW0: begin
				we    = 1'b1;
				wdata = TOTAL_W'(s_q);
			end
			ROWN: begin
				if (short) begin
					we    = 1'b1;
					wdata = '0;
				end else begin
					b_rd = i_q < 4'd10;
					we   = i_q == 4'd10;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ROW0;
			wr_addr_q <= '0;
			s_q       <= '0;
			i_q       <= '0;
			acc_q     <= '0;
		end else begin
			case (state_q)
				ROW0, ROWN: begin
					if (state_q == ROWN && !short) begin
						i_q   <= i_q + 4'd1;
						acc_q <= (i_q == 4'd0) ? '0 : acc_q + rdata_q;
					end
					if (we) begin
						i_q       <= '0;
						acc_q     <= '0;
						wr_addr_q <= wr_addr_q + ADDR_W'(1);
						s_q       <= (s_q == 8'(SPAN - 1)) ? '0 : s_q + 8'd1;
						if (last) begin
							state_q <= DONE;
						end else if (s_q == 8'(SPAN - 1)) begin
							state_q <= ROWN;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr_q] <= wdata;
		end
		if (b_rd) begin
			rdata_q <= mem[b_addr];
		end else if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = rdata_q;
	assign built   = state_q == DONE;

endmodule

>>> rtl/rds_b2d.sv
// ----------------------------------------------------------------------------
// rds_b2d
// Bit-serial binary to BCD converter (shift and add three), one bit a cycle.
// ----------------------------------------------------------------------------
module rds_b2d #(
	parameter int MAX_DIGITS = 16,
	parameter int BW         = 4 * MAX_DIGITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rds_pkg::BOUND_W-1:0] value,
	output logic                        busy,
	output logic [BW-1:0]               digits
);
	import rds_pkg::*;

	localparam int CW = $clog2(BOUND_W + 1);

	logic [BOUND_W-1:0] sh_q;
	logic [BW-1:0]      bcd_q;
	logic [CW-1:0]      cnt_q;
	logic [BW-1:0]      adj;

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			adj[k*4 +: 4] = (bcd_q[k*4 +: 4] >= 4'd5) ? bcd_q[k*4 +: 4] + 4'd3
				: bcd_q[k*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(BOUND_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			sh_q  <= {sh_q[BOUND_W-2:0], 1'b0};
			bcd_q <= {adj[BW-2:0], sh_q[BOUND_W-1]};
		end
	end

	assign busy   = cnt_q != '0;
	assign digits = bcd_q;

endmodule

>>> rtl/range_digit_sum_top.sv
// ----------------------------------------------------------------------------
// range_digit_sum_top
// Sum of all decimal digits of every integer in [lower, upper], by digit DP.
// ----------------------------------------------------------------------------
// After reset the suffix table is built; s_tready stays low until then. Each
// word then takes one bound walk for the upper bound and, unless lower is
// zero, one for lower-1. A walk is a bit-serial decimal conversion, then a
// pass over the digits from the most significant that tries each smaller
// choice of each digit, then a closing drain step. A reversed range skips
// the walks and answers directly. The table's single read port sets the walk
// rate. One word is in flight at a time; the result register lets the next
// word in while a result waits.
module range_digit_sum_top #(
	parameter int MAX_DIGITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // lower_bound[53:0], upper_bound[107:54], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // digit_sum_total[59:0], zero pad
	output logic         m_tuser    // range_error
);
	import rds_pkg::*;

	localparam int SPAN   = 9 * MAX_DIGITS + 1;
	localparam int DEPTH  = MAX_DIGITS * SPAN;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int KW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int BW     = 4 * MAX_DIGITS;
	localparam logic [63:0] TOP = pow10_m1(MAX_DIGITS);

	typedef enum logic [2:0] {IDLE, CONV, WALK, DRAIN, FIN} state_t;

	state_t             state_q;
	logic               pass_q;
	logic               lo_zero_q;
	logic [BOUND_W-1:0] lo_m1_q;
	logic [KW-1:0]      k_q;
	logic [3:0]         i_q;
	logic [7:0]         prefix_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] ghi_q;
	logic [ADDR_W-1:0]  base_q;
	logic               vld_s1;
	logic [TOTAL_W-1:0] res_q;
	logic               err_q;
	logic               out_vld_q;
	logic [TOTAL_W-1:0] out_data_q;
	logic               out_err_q;

	logic [BOUND_W-1:0] lo_in, hi_in, lo_sat, hi_sat;
	logic               conv_start;
	logic [BOUND_W-1:0] conv_val;
	logic               conv_busy;
	logic [BW-1:0]      digits;
	logic               built;
	logic [TOTAL_W-1:0] rd_data;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [3:0]         d;
	logic [8:0]         s_sum;
	logic [TOTAL_W-1:0] walk_total;
	logic               accept;

	assign lo_in  = s_tdata[53:0];
	assign hi_in  = s_tdata[107:54];
	assign lo_sat = ({10'd0, lo_in} > TOP) ? TOP[BOUND_W-1:0] : lo_in;
	assign hi_sat = ({10'd0, hi_in} > TOP) ? TOP[BOUND_W-1:0] : hi_in;
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == IDLE) && built;

	assign d      = digits[{k_q, 2'b00} +: 4];
	assign s_sum  = {1'b0, prefix_q} + {5'd0, i_q};
	assign rd_en  = (state_q == WALK) && (i_q < d) && (s_sum < 9'(SPAN));
	assign rd_addr = base_q + ADDR_W'(s_sum);
	assign walk_total = total_q + (vld_s1 ? rd_data : '0) + TOTAL_W'(prefix_q);

	always_comb begin
		conv_start = 1'b0;
		conv_val   = hi_sat;
		if (accept && lo_in <= hi_in) begin
			conv_start = 1'b1;
		end else if (state_q == DRAIN && !pass_q && !lo_zero_q) begin
			conv_start = 1'b1;
			conv_val   = lo_m1_q;
		end
	end

	rds_table #(.MAX_DIGITS(MAX_DIGITS), .SPAN(SPAN), .DEPTH(DEPTH), .ADDR_W(ADDR_W))
	u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.built  (built)
	);

	rds_b2d #(.MAX_DIGITS(MAX_DIGITS), .BW(BW)) u_b2d (
		.clk   (clk),
		.arst_n(arst_n),
		.start (conv_start),
		.value (conv_val),
		.busy  (conv_busy),
		.digits(digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			pass_q    <= 1'b0;
			k_q       <= '0;
			i_q       <= '0;
			prefix_q  <= '0;
			total_q   <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (lo_in > hi_in) begin
							res_q   <= '0;
							err_q   <= 1'b1;
							state_q <= FIN;
						end else begin
							lo_zero_q <= lo_sat == '0;
							lo_m1_q   <= lo_sat - BOUND_W'(1);
							pass_q    <= 1'b0;
							err_q     <= 1'b0;
							state_q   <= CONV;
						end
					end
				end
				CONV: begin
					if (!conv_busy) begin
						k_q      <= KW'(MAX_DIGITS - 1);
						base_q   <= ADDR_W'((MAX_DIGITS - 1) * SPAN);
						i_q      <= '0;
						prefix_q <= '0;
						total_q  <= '0;
						state_q  <= WALK;
					end
				end
				WALK: begin
					if (vld_s1) begin
						total_q <= total_q + rd_data;
					end
					if (i_q < d) begin
						i_q <= i_q + 4'd1;
					end else begin
						i_q      <= '0;
						prefix_q <= prefix_q + {4'd0, d};
						if (k_q == '0) begin
							state_q <= DRAIN;
						end else begin
							k_q    <= k_q - KW'(1);
							base_q <= base_q - ADDR_W'(SPAN);
						end
					end
				end
				DRAIN: begin
					if (!pass_q) begin
						ghi_q <= walk_total;
						if (lo_zero_q) begin
							res_q   <= walk_total;
							state_q <= FIN;
						end else begin
							pass_q  <= 1'b1;
							state_q <= CONV;
						end
					end else begin
						res_q   <= ghi_q - walk_total;
						state_q <= FIN;
					end
				end
				FIN: begin
					if (!out_vld_q || m_tready) begin
						out_vld_q  <= 1'b1;
						out_data_q <= res_q;
						out_err_q  <= err_q;
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_data_q};
	assign m_tuser  = out_err_q;

`ifndef SYNTH
	a_no_accept_unbuilt: assert property (@(posedge clk) disable iff (!arst_n)
		!built |-> !s_tready) else $error("input taken before table built");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 64'd0) else $error("error result not zero");
	a_walk_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WALK |-> !conv_busy) else $error("walk during conversion");
`endif

endmodule
